// ===== src/dtwr_pkg.sv =====
// Shared types and constants for the two-way ranging antenna delay calibrator.
// No dependencies; used by every module of the block.
package dtwr_pkg;

    localparam int unsigned RANGE_W    = 40;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned FLIGHT_W   = 32;
    localparam int unsigned DIST_W     = 32;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned SUM_W      = 40;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned NUM_W      = 64;
    localparam int unsigned DEN_W      = 42;
    localparam int unsigned SCALE_P_W  = FLIGHT_W + CFG_W;
    localparam int unsigned GPROD_W    = SUM_W + CFG_W;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned PDATA_W    = 32;
    localparam int unsigned S_TDATA_W  = 2 * RANGE_W + 3 * STAMP_W;
    localparam int unsigned M_TDATA_W  = FLIGHT_W + DIST_W + 2 * DELAY_W;
    localparam int unsigned M_TUSER_W  = 2;

    localparam int unsigned SAMPLES_DEFAULT = 10;

    localparam logic [CFG_W-1:0] CALIB_RESET   = 16'd0;
    localparam logic [CFG_W-1:0] SCALE_RESET   = 16'd30738;
    localparam logic [CFG_W-1:0] GAIN_RESET    = 16'd491;
    localparam logic [CFG_W-1:0] TX_INIT_RESET = 16'd16436;
    localparam logic [CFG_W-1:0] RX_INIT_RESET = 16'd16436;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_CALIB_DIST  = 3'd0;
    localparam logic [2:0] REG_DIST_SCALE  = 3'd1;
    localparam logic [2:0] REG_OFFSET_GAIN = 3'd2;
    localparam logic [2:0] REG_TX_INIT     = 3'd3;
    localparam logic [2:0] REG_RX_INIT     = 3'd4;

    // One classified exchange as it waits in the queue.
    typedef struct packed {
        logic                   exchange_ok;
        logic [RANGE_W-1:0]     round_one;
        logic [RANGE_W-1:0]     reply_one;
        logic [STAMP_W-1:0]     round_two;
        logic [STAMP_W-1:0]     reply_two;
    } xchg_t;

    // Delay register loads caused by configuration writes.
    typedef struct packed {
        logic               tx_load;
        logic               rx_load;
        logic [CFG_W-1:0]   value;
    } delay_load_t;

endpackage

// ===== src/dtwr_front.sv =====
// Input side: accepts exchange transactions and forms the local round and reply intervals.
// Depends on dtwr_pkg; feeds dtwr_fifo.
module dtwr_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // round_one[39:0], reply_one[79:40], poll_rx_time[111:80],
    // resp_tx_time[143:112], final_rx_time[175:144]
    input  logic [dtwr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // exchange_ok[0]
    input  logic                               s_axis_tuser,
    output logic                               push,
    output dtwr_pkg::xchg_t                    push_data,
    input  logic                               push_ready
);

    localparam int unsigned RW = dtwr_pkg::RANGE_W;
    localparam int unsigned TW = dtwr_pkg::STAMP_W;

    dtwr_pkg::xchg_t hold_reg;
    logic            hold_valid_reg;
    logic            accept;
    logic [TW-1:0]   poll_rx_time;
    logic [TW-1:0]   resp_tx_time;
    logic [TW-1:0]   final_rx_time;

    assign poll_rx_time  = s_axis_tdata[2*RW +: TW];
    assign resp_tx_time  = s_axis_tdata[2*RW+TW +: TW];
    assign final_rx_time = s_axis_tdata[2*RW+2*TW +: TW];

    assign s_axis_tready = !hold_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = hold_valid_reg;
    assign push_data     = hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (push_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Local intervals wrap at 32 bits.
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg.exchange_ok <= s_axis_tuser;
            hold_reg.round_one   <= s_axis_tdata[0 +: RW];
            hold_reg.reply_one   <= s_axis_tdata[RW +: RW];
            hold_reg.round_two   <= final_rx_time - resp_tx_time;
            hold_reg.reply_two   <= resp_tx_time - poll_rx_time;
        end
    end

endmodule

// ===== src/dtwr_fifo.sv =====
// Short queue of classified exchanges between the input side and the compute engine.
// Depends on dtwr_pkg for the entry type and depth.
module dtwr_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dtwr_pkg::xchg_t  push_data,
    output logic             push_ready,
    input  logic             pop,
    output dtwr_pkg::xchg_t  head,
    output logic             head_valid
);

    localparam int unsigned DEPTH = dtwr_pkg::FIFO_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dtwr_pkg::xchg_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign push_ok    = push && push_ready;
    assign pop_ok     = pop && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_ok) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_ok && !push_ok) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds its depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

endmodule

// ===== src/dtwr_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by the flight time and
// the round average. Depends on dtwr_pkg for operand widths.
module dtwr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dtwr_pkg::NUM_W-1:0]   dividend,
    input  logic [dtwr_pkg::DEN_W-1:0]   divisor,
    output logic                         done,
    output logic [dtwr_pkg::NUM_W-1:0]   quotient
);

    localparam int unsigned NW    = dtwr_pkg::NUM_W;
    localparam int unsigned DW    = dtwr_pkg::DEN_W;
    localparam int unsigned CNT_W = $clog2(NW);

    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;

    // Partial remainder stays below the divisor, so the shifted trial fits in DW+1 bits.
    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

endmodule

// ===== src/dtwr_back.sv =====
// Compute engine: flight time, distance, round averaging and delay correction.
// Depends on dtwr_pkg and dtwr_div; drains dtwr_fifo and owns the result register.
module dtwr_back #(
    parameter int unsigned SAMPLES_PER_ROUND = dtwr_pkg::SAMPLES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dtwr_pkg::xchg_t                    head,
    input  logic                               head_valid,
    output logic                               pop,
    input  logic [dtwr_pkg::CFG_W-1:0]         calib_distance_cm,
    input  logic [dtwr_pkg::CFG_W-1:0]         dist_scale,
    input  logic [dtwr_pkg::CFG_W-1:0]         offset_gain,
    input  dtwr_pkg::delay_load_t              delay_load,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [dtwr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [dtwr_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    localparam int unsigned NW  = dtwr_pkg::NUM_W;
    localparam int unsigned DW  = dtwr_pkg::DEN_W;
    localparam int unsigned FW  = dtwr_pkg::FLIGHT_W;
    localparam int unsigned XW  = dtwr_pkg::DIST_W;
    localparam int unsigned SW  = dtwr_pkg::SUM_W;
    localparam int unsigned CW  = dtwr_pkg::COUNT_W;
    localparam int unsigned LW  = dtwr_pkg::DELAY_W;
    localparam int unsigned GW  = dtwr_pkg::GPROD_W;
    localparam int unsigned PW  = dtwr_pkg::SCALE_P_W;
    localparam int unsigned KW  = dtwr_pkg::CFG_W;
    localparam int unsigned HW  = NW / 2;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_MUL   = 9'b0_0000_0010,
        S_DIV   = 9'b0_0000_0100,
        S_SCALE = 9'b0_0000_1000,
        S_ACC   = 9'b0_0001_0000,
        S_AVG   = 9'b0_0010_0000,
        S_GAIN  = 9'b0_0100_0000,
        S_STEP  = 9'b0_1000_0000,
        S_EMIT  = 9'b1_0000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    dtwr_pkg::xchg_t   ent_reg;
    logic [2:0]        mcnt_reg;
    logic [NW-1:0]     prod_reg;
    logic [NW-1:0]     num_reg;
    logic [DW-1:0]     den_reg;
    logic [FW-1:0]     flight_reg;
    logic [XW-1:0]     dist_reg;
    logic [SW-1:0]     sum_reg;
    logic [SW-1:0]     sum_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [LW-1:0]     tx_delay_reg;
    logic [LW-1:0]     rx_delay_reg;
    logic              done_flag_reg;
    logic              round_done_reg;
    logic              neg_reg;
    logic [SW-1:0]     mag_reg;
    logic [GW-1:0]     gprod_reg;
    logic              out_valid_reg;
    logic [dtwr_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [dtwr_pkg::M_TUSER_W-1:0] out_user_reg;

    logic [HW-1:0]     mul_a;
    logic [HW-1:0]     mul_b;
    logic [NW-1:0]     mul_p;
    logic [2:0]        term_k;
    logic [NW-1:0]     term;
    logic              div_start;
    logic [NW-1:0]     div_dividend;
    logic [DW-1:0]     div_divisor;
    logic              div_done;
    logic [NW-1:0]     div_quot;
    logic [FW-1:0]     flight_sat;
    logic [PW-1:0]     scale_p;
    logic [SW-1:0]     avg;
    logic              avg_lt;
    logic              round_end;
    logic [GW-9:0]     omag;
    logic [31:0]       omag_sat;
    logic [32:0]       smag_wide;
    logic [31:0]       smag;
    logic [LW-1:0]     step_bits;
    logic              converged;
    logic              emit_ok;

    // Numerator terms: R1 and D1 are split into a low 32-bit and a high 8-bit part.
    always_comb begin
        case (mcnt_reg)
            3'd0: begin
                mul_a = ent_reg.round_one[HW-1:0];
                mul_b = ent_reg.round_two;
            end
            3'd1: begin
                mul_a = HW'(ent_reg.round_one[dtwr_pkg::RANGE_W-1:HW]);
                mul_b = ent_reg.round_two;
            end
            3'd2: begin
                mul_a = ent_reg.reply_one[HW-1:0];
                mul_b = ent_reg.reply_two;
            end
            3'd3: begin
                mul_a = HW'(ent_reg.reply_one[dtwr_pkg::RANGE_W-1:HW]);
                mul_b = ent_reg.reply_two;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = NW'(mul_a) * NW'(mul_b);
    assign term_k = mcnt_reg - 3'd1;
    // High-part products weigh 2^32; only their low half survives the 64-bit wrap.
    assign term   = term_k[0] ? {prod_reg[HW-1:0], {HW{1'b0}}} : prod_reg;

    assign sum_next   = sum_reg + SW'(dist_reg);
    assign count_next = count_reg + 1'b1;
    assign round_end  = (count_next >= CW'(SAMPLES_PER_ROUND));

    assign flight_sat = (div_quot[NW-1:FW] != '0) ? {FW{1'b1}} : div_quot[FW-1:0];
    assign scale_p    = PW'(flight_reg) * PW'(dist_scale);
    assign avg        = div_quot[SW-1:0];
    assign avg_lt     = (avg < SW'(calib_distance_cm));

    // Offset is truncated toward zero and clamped to signed 32 bits, then halved with
    // rounding toward minus infinity.
    always_comb begin
        omag = gprod_reg[GW-1:8];
        if (neg_reg) begin
            omag_sat = (omag > (GW-8)'(32'h8000_0000)) ? 32'h8000_0000 : omag[31:0];
        end else begin
            omag_sat = (omag > (GW-8)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : omag[31:0];
        end
        smag_wide = {1'b0, omag_sat} + {32'd0, neg_reg};
        smag      = smag_wide[32:1];
        step_bits = neg_reg ? (LW'(0) - smag[LW-1:0]) : smag[LW-1:0];
        converged = (smag[31:1] == '0);
    end

    assign emit_ok = !out_valid_reg || m_axis_tready;
    assign pop     = (state_reg == S_IDLE) && head_valid;

    always_comb begin
        div_start = ((state_reg == S_MUL) && (mcnt_reg == 3'd5) && (den_reg != '0))
                 || ((state_reg == S_ACC) && !done_flag_reg && round_end);
        if (state_reg == S_ACC) begin
            div_dividend = NW'(sum_next);
            div_divisor  = DW'(SAMPLES_PER_ROUND);
        end else begin
            div_dividend = num_reg;
            div_divisor  = den_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (head_valid) begin
                    state_next = head.exchange_ok ? S_MUL : S_EMIT;
                end
            end
            S_MUL: begin
                if (mcnt_reg == 3'd5) begin
                    state_next = (den_reg == '0) ? S_SCALE : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: state_next = S_ACC;
            S_ACC: begin
                state_next = (!done_flag_reg && round_end) ? S_AVG : S_EMIT;
            end
            S_AVG: begin
                if (div_done) begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN: state_next = S_STEP;
            S_STEP: state_next = S_EMIT;
            S_EMIT: begin
                if (emit_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    dtwr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            tx_delay_reg  <= dtwr_pkg::TX_INIT_RESET;
            rx_delay_reg  <= dtwr_pkg::RX_INIT_RESET;
            done_flag_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_EMIT) && emit_ok) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_ACC) && !done_flag_reg) begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            if (state_reg == S_STEP) begin
                tx_delay_reg <= tx_delay_reg + step_bits;
                rx_delay_reg <= rx_delay_reg + step_bits;
                sum_reg      <= '0;
                count_reg    <= '0;
                if (converged) begin
                    done_flag_reg <= 1'b1;
                end
            end
            if (delay_load.tx_load) begin
                tx_delay_reg <= delay_load.value[LW-1:0];
            end
            if (delay_load.rx_load) begin
                rx_delay_reg <= delay_load.value[LW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (head_valid) begin
                    ent_reg        <= head;
                    num_reg        <= '0;
                    mcnt_reg       <= '0;
                    den_reg        <= DW'(head.round_one) + DW'(head.reply_one);
                    flight_reg     <= '0;
                    dist_reg       <= '0;
                    round_done_reg <= 1'b0;
                end
            end
            S_MUL: begin
                prod_reg <= mul_p;
                mcnt_reg <= mcnt_reg + 3'd1;
                if ((mcnt_reg != 3'd0) && (mcnt_reg <= 3'd4)) begin
                    num_reg <= term_k[1] ? (num_reg - term) : (num_reg + term);
                end
                if (mcnt_reg == 3'd0) begin
                    den_reg <= den_reg + DW'(ent_reg.round_two);
                end
                if (mcnt_reg == 3'd1) begin
                    den_reg <= den_reg + DW'(ent_reg.reply_two);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    flight_reg <= flight_sat;
                end
            end
            S_SCALE: dist_reg <= scale_p[PW-1:KW];
            S_ACC: begin
                if (!done_flag_reg && round_end) begin
                    round_done_reg <= 1'b1;
                end
            end
            S_AVG: begin
                if (div_done) begin
                    neg_reg <= avg_lt;
                    mag_reg <= avg_lt ? (SW'(calib_distance_cm) - avg)
                                      : (avg - SW'(calib_distance_cm));
                end
            end
            S_GAIN: gprod_reg <= GW'(mag_reg) * GW'(offset_gain);
            S_EMIT: begin
                if (emit_ok) begin
                    out_data_reg <= {rx_delay_reg, tx_delay_reg, dist_reg, flight_reg};
                    out_user_reg <= {done_flag_reg, round_done_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && done_flag_reg) |=> done_flag_reg)
        else $error("calibrated flag dropped without reset");

    a_delay_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && (state_reg != S_STEP) && !delay_load.tx_load && !delay_load.rx_load)
        |=> ($stable(tx_delay_reg) && $stable(rx_delay_reg)))
        else $error("antenna delay changed outside a correction step");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(SAMPLES_PER_ROUND))
        else $error("sample count ran past the round length");

endmodule

// ===== src/ds_twr_antenna_delay_calibrator.sv =====
// Top level of the two-way ranging antenna delay calibrator: APB register file and
// the front, queue and compute engine. Depends on dtwr_pkg, dtwr_front, dtwr_fifo, dtwr_back.
//
// Usage: each transaction on the s_axis channel carries the timestamps of one
// double-sided ranging exchange; exactly one result transaction leaves on m_axis for
// each, in order. The result holds the flight time in ticks, the distance in
// centimetres and the antenna delays after this exchange, with flags for a completed
// averaging round and for convergence.
// A good exchange runs through the bit-serial divider and the shared 32x32 multiplier,
// which a failed one skips. An exchange that closes an averaging round takes longer,
// since the round average runs through the same divider. One exchange is computed at a
// time: the engine takes a new one only after the last result is emitted, and a
// two-entry queue and an input holding register keep accepting meanwhile.
// Reset (aresetn low, synchronous) restores all APB registers to their defaults, loads the
// antenna delays from the init defaults and clears the average and calibrated flag.
// If the receiver stalls, the finished result waits in the output register, the engine
// computes the next one, then the queue fills and s_axis_tready falls. Registers must be
// written over APB only while no exchange is in flight; the block does not enforce this.
module ds_twr_antenna_delay_calibrator #(
    parameter int unsigned SAMPLES_PER_ROUND = dtwr_pkg::SAMPLES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // round_one[39:0], reply_one[79:40], poll_rx_time[111:80],
    // resp_tx_time[143:112], final_rx_time[175:144]
    input  logic [dtwr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // exchange_ok[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // flight_ticks[31:0], distance_cm[63:32], tx_delay[79:64], rx_delay[95:80]
    output logic [dtwr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // round_done[0], calibrated[1]
    output logic [dtwr_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dtwr_pkg::ADDR_W-1:0]        paddr,
    input  logic [dtwr_pkg::PDATA_W-1:0]       pwdata,
    output logic [dtwr_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int unsigned KW = dtwr_pkg::CFG_W;
    localparam int unsigned DW = dtwr_pkg::PDATA_W;

    logic [KW-1:0]           calib_reg;
    logic [KW-1:0]           scale_reg;
    logic [KW-1:0]           gain_reg;
    logic [KW-1:0]           tx_init_reg;
    logic [KW-1:0]           rx_init_reg;
    logic [2:0]              reg_idx;
    logic                    wr_en;
    dtwr_pkg::delay_load_t   delay_load;

    logic                    push;
    dtwr_pkg::xchg_t         push_data;
    logic                    push_ready;
    logic                    pop;
    dtwr_pkg::xchg_t         head;
    logic                    head_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dtwr_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        delay_load.tx_load = wr_en && (reg_idx == dtwr_pkg::REG_TX_INIT);
        delay_load.rx_load = wr_en && (reg_idx == dtwr_pkg::REG_RX_INIT);
        delay_load.value   = pwdata[KW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg   <= dtwr_pkg::CALIB_RESET;
            scale_reg   <= dtwr_pkg::SCALE_RESET;
            gain_reg    <= dtwr_pkg::GAIN_RESET;
            tx_init_reg <= dtwr_pkg::TX_INIT_RESET;
            rx_init_reg <= dtwr_pkg::RX_INIT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                dtwr_pkg::REG_CALIB_DIST:  calib_reg   <= pwdata[KW-1:0];
                dtwr_pkg::REG_DIST_SCALE:  scale_reg   <= pwdata[KW-1:0];
                dtwr_pkg::REG_OFFSET_GAIN: gain_reg    <= pwdata[KW-1:0];
                dtwr_pkg::REG_TX_INIT:     tx_init_reg <= pwdata[KW-1:0];
                dtwr_pkg::REG_RX_INIT:     rx_init_reg <= pwdata[KW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dtwr_pkg::REG_CALIB_DIST:  prdata = DW'(calib_reg);
            dtwr_pkg::REG_DIST_SCALE:  prdata = DW'(scale_reg);
            dtwr_pkg::REG_OFFSET_GAIN: prdata = DW'(gain_reg);
            dtwr_pkg::REG_TX_INIT:     prdata = DW'(tx_init_reg);
            dtwr_pkg::REG_RX_INIT:     prdata = DW'(rx_init_reg);
            default:                   prdata = '0;
        endcase
    end

    dtwr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_data     (push_data),
        .push_ready    (push_ready)
    );

    dtwr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    dtwr_back #(
        .SAMPLES_PER_ROUND (SAMPLES_PER_ROUND)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (head),
        .head_valid        (head_valid),
        .pop               (pop),
        .calib_distance_cm (calib_reg),
        .dist_scale        (scale_reg),
        .offset_gain       (gain_reg),
        .delay_load        (delay_load),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tuser      (m_axis_tuser)
    );

endmodule
